>>> sv/canvas_shape_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// canvas shape rasterizer assertion macros
// concurrent checks used by the rasterizer rtl, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef CANVAS_SHAPE_RASTERIZER_ASSERT_SVH
`define CANVAS_SHAPE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CSR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("csr assertion failed");
// consequent must hold in the cycle after the antecedent
`define CSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csr assertion failed");
`else
`define CSR_ASSERT(label, clk, rst_n, prop)
`define CSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/csr_pkg.sv
// ----------------------------------------------------------------------------
// csr_pkg
// shared types, constants and shape geometry for the canvas shape rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package csr_pkg;

	localparam int COLS    = 64;
	localparam int ROWS    = 64;
	localparam int ROW_AW  = $clog2(ROWS);
	localparam int COL_AW  = $clog2(COLS);
	localparam int CFG_W   = 7;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 72;

	localparam logic [CFG_W-1:0] MAX_WIDTH  = 7'd64;
	localparam logic [CFG_W-1:0] MAX_HEIGHT = 7'd64;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// shape codes
	localparam logic [1:0] FUNC_LINE     = 2'd0;
	localparam logic [1:0] FUNC_SQUARE   = 2'd1;
	localparam logic [1:0] FUNC_TRIANGLE = 2'd2;
	localparam logic [1:0] FUNC_NONE     = 2'd3;

	// triangle orientations
	localparam logic [1:0] DIR_UP_LEFT    = 2'd0;
	localparam logic [1:0] DIR_DOWN_LEFT  = 2'd1;
	localparam logic [1:0] DIR_UP_RIGHT   = 2'd2;
	localparam logic [1:0] DIR_DOWN_RIGHT = 2'd3;

	typedef logic signed [9:0] coord_t;

	typedef struct packed {
		coord_t xa;
		coord_t ya;
		coord_t xb;
		coord_t yb;
	} line_ends_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SETUP,
		ST_STEP,
		ST_DRAIN,
		ST_READ,
		ST_LOAD,
		ST_ERROR
	} state_t;

	typedef struct packed {
		logic       load_cmd;
		logic       setup;
		logic       step;
		logic       row_clr;
		logic       rd_row;
		logic       ld_out;
		logic       err_out;
		logic [1:0] line_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic zero_lines;
		logic ends_ok;
		logic at_end;
		logic last_line;
		logic row_last;
		logic out_free;
	} ctrl_sts_t;

	function automatic logic [2:0] line_count(input logic [1:0] func);
		logic [2:0] n;
		unique case (func)
			FUNC_LINE:     n = 3'd1;
			FUNC_SQUARE:   n = 3'd4;
			FUNC_TRIANGLE: n = 3'd3;
			default:       n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic line_ends_t mk_line(input coord_t xa, input coord_t ya,
		input coord_t xb, input coord_t yb);
		line_ends_t l;
		l.xa = xa;
		l.ya = ya;
		l.xb = xb;
		l.yb = yb;
		return l;
	endfunction

	// end points of line k of a shape; e is the side length minus one
	function automatic line_ends_t line_ends(input logic [1:0] func, input logic [1:0] dir,
		input logic [1:0] k, input coord_t x, input coord_t y, input coord_t x2,
		input coord_t y2, input coord_t e);
		coord_t xp, xm, yp, ym;
		line_ends_t l;
		xp = x + e;
		xm = x - e;
		yp = y + e;
		ym = y - e;
		l = mk_line(x, y, x2, y2);
		unique case (func)
			FUNC_SQUARE: begin
				unique case (k)
					2'd0:    l = mk_line(xp, y, xp, yp);
					2'd1:    l = mk_line(x, yp, xp, yp);
					2'd2:    l = mk_line(x, y, x, yp);
					default: l = mk_line(x, y, xp, y);
				endcase
			end
			FUNC_TRIANGLE: begin
				unique case (dir)
					DIR_UP_LEFT: begin
						unique case (k)
							2'd0:    l = mk_line(x, y, xm, y);
							2'd1:    l = mk_line(x, y, x, ym);
							default: l = mk_line(xm, y, x, ym);
						endcase
					end
					DIR_DOWN_LEFT: begin
						unique case (k)
							2'd0:    l = mk_line(x, y, x, yp);
							2'd1:    l = mk_line(x, y, xm, y);
							default: l = mk_line(xm, y, x, yp);
						endcase
					end
					DIR_UP_RIGHT: begin
						unique case (k)
							2'd0:    l = mk_line(x, y, xp, y);
							2'd1:    l = mk_line(x, y, x, ym);
							default: l = mk_line(xp, y, x, ym);
						endcase
					end
					default: begin
						unique case (k)
							2'd0:    l = mk_line(xp, y, x, yp);
							2'd1:    l = mk_line(x, y, xp, y);
							default: l = mk_line(x, y, x, yp);
						endcase
					end
				endcase
			end
			default: l = mk_line(x, y, x2, y2);
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

>>> sv/canvas_shape_rasterizer.sv
// ----------------------------------------------------------------------------
// canvas_shape_rasterizer
// one-bit canvas drawing lines, squares and right triangles, with row readout
// ----------------------------------------------------------------------------
// usage:
//  - commands enter on s_axis; one transaction is one shape (line, square,
//    triangle); func code 3 draws nothing but still reads the canvas out
//  - each line is drawn only if both end points are on the canvas; the first
//    failing line ends the shape and a single m_axis transaction with tuser
//    set and tlast set reports it; lines drawn before it are kept
//  - otherwise m_axis gives every row in use, row 0 first, tlast on the last
//  - cfg_we/cfg_index/cfg_data set width (index 0) and height (index 1);
//    write only while the block is idle
//  - the pixel path does one read-modify-write of the row store per cycle
//    while a line is stepped, through a forwarded two-stage pipe; readout
//    reads one row from the store, then loads it into the output register
//  - reset clears the canvas through per-row valid flags, so no clear pass
//  - a stalled receiver holds the output register; the block accepts the
//    next command once the previous readout or error report is in that register
// ----------------------------------------------------------------------------
`default_nettype none

module canvas_shape_rasterizer import csr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write port
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	// command stream
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// func[1:0], x1[9:2], y1[17:10], x2[25:18], y2[33:26], size[40:34],
	// dir[42:41], zero pad[47:43]
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// row stream
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// row_index[5:0], row_bits[69:6], zero pad[71:70]
	output logic [OUT_W-1:0]      m_axis_tdata,
	// out_of_range[0]
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer: shape lines, then readout or error report
	csr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stepper, canvas store and output register
	csr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_err   (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

>>> sv/csr_canvas_mem.sv
// ----------------------------------------------------------------------------
// csr_canvas_mem
// canvas row store, one write and one registered read per cycle, with a
// per-row valid flag so that rows never written read as blank
// ----------------------------------------------------------------------------
`default_nettype none

module csr_canvas_mem import csr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [ROW_AW-1:0] waddr,
	input  wire logic [COLS-1:0]   wdata,
	input  wire logic              re,
	input  wire logic [ROW_AW-1:0] raddr,
	output logic      [COLS-1:0]   rdata,
	output logic                   rvalid
);

	logic [COLS-1:0] mem_q [ROWS];
	logic [COLS-1:0] rdata_q;
	logic [ROWS-1:0] row_valid_q;
	logic            rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= row_valid_q[raddr];
			end
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule

`default_nettype wire

>>> sv/csr_ctrl.sv
// ----------------------------------------------------------------------------
// csr_ctrl
// command sequencer: walks the lines of a shape, then the row readout or
// the error report
// ----------------------------------------------------------------------------
`default_nettype none

module csr_ctrl import csr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	state_t     state_q, state_d;
	logic [1:0] line_q, line_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			line_q  <= line_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		line_d       = line_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.line_sel = line_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_cmd = 1'b1;
					line_d       = 2'd0;
					state_d      = ST_START;
				end
			end
			ST_START: begin
				state_d = sts.zero_lines ? ST_DRAIN : ST_SETUP;
			end
			ST_SETUP: begin
				if (sts.ends_ok) begin
					cmd.setup = 1'b1;
					state_d   = ST_STEP;
				end else begin
					state_d = ST_ERROR;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (sts.at_end) begin
					if (sts.last_line) begin
						state_d = ST_DRAIN;
					end else begin
						line_d  = line_q + 2'd1;
						state_d = ST_SETUP;
					end
				end
			end
			ST_DRAIN: begin
				cmd.row_clr = 1'b1;
				state_d     = ST_READ;
			end
			ST_READ: begin
				if (sts.out_free) begin
					cmd.rd_row = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.ld_out = 1'b1;
				state_d    = sts.row_last ? ST_IDLE : ST_READ;
			end
			ST_ERROR: begin
				if (sts.out_free) begin
					cmd.err_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/csr_datapath.sv
// ----------------------------------------------------------------------------
// csr_datapath
// command and config registers, line stepper, pixel read-modify-write pipe,
// row readout and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "canvas_shape_rasterizer_assert.svh"

module csr_datapath import csr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic [IN_W-1:0]  in_data,
	input  wire ctrl_cmd_t        cmd,
	output ctrl_sts_t             sts,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_data,
	output logic                  out_err,
	output logic                  out_last
);

	// configuration
	logic [CFG_W-1:0] width_q, height_q, weff, heff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_WIDTH;
			height_q <= MAX_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				default:    height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		weff = width_q;
		if (weff == '0) weff = 7'd1;
		if (weff > MAX_WIDTH) weff = MAX_WIDTH;
		heff = height_q;
		if (heff == '0) heff = 7'd1;
		if (heff > MAX_HEIGHT) heff = MAX_HEIGHT;
	end

	// command registers
	logic [1:0] func_q, dir_q;
	logic [7:0] x1_q, y1_q, x2_q, y2_q;
	logic [6:0] size_q;

	always_ff @(posedge clk) begin
		if (cmd.load_cmd) begin
			func_q <= in_data[1:0];
			x1_q   <= in_data[9:2];
			y1_q   <= in_data[17:10];
			x2_q   <= in_data[25:18];
			y2_q   <= in_data[33:26];
			size_q <= in_data[40:34];
			dir_q  <= in_data[42:41];
		end
	end

	line_ends_t ends;
	coord_t     side_m1;
	logic [2:0] n_lines;
	logic       a_ok, b_ok;

	assign side_m1 = $signed({3'b000, size_q}) - 10'sd1;
	assign ends    = line_ends(func_q, dir_q, cmd.line_sel,
		coord_t'($signed(x1_q)), coord_t'($signed(y1_q)),
		coord_t'($signed(x2_q)), coord_t'($signed(y2_q)), side_m1);
	assign n_lines = line_count(func_q);

	assign a_ok = !ends.xa[9] && !ends.ya[9]
		&& (ends.xa < $signed({3'b000, weff})) && (ends.ya < $signed({3'b000, heff}));
	assign b_ok = !ends.xb[9] && !ends.yb[9]
		&& (ends.xb < $signed({3'b000, weff})) && (ends.yb < $signed({3'b000, heff}));

	// line stepper: each axis moves toward its end and then holds
	logic [COL_AW-1:0] cx_q, xb_q;
	logic [ROW_AW-1:0] cy_q, yb_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			cx_q <= ends.xa[COL_AW-1:0];
			cy_q <= ends.ya[ROW_AW-1:0];
			xb_q <= ends.xb[COL_AW-1:0];
			yb_q <= ends.yb[ROW_AW-1:0];
		end else if (cmd.step) begin
			if (xb_q > cx_q) cx_q <= cx_q + 1'b1;
			else if (xb_q < cx_q) cx_q <= cx_q - 1'b1;
			if (yb_q > cy_q) cy_q <= cy_q + 1'b1;
			else if (yb_q < cy_q) cy_q <= cy_q - 1'b1;
		end
	end

	// pixel pipe: the step cycle reads the row, s1 merges the pixel and writes back
	logic              v_s1;
	logic [COL_AW-1:0] x_s1;
	logic [ROW_AW-1:0] y_s1;
	logic              fwd_v_q;
	logic [ROW_AW-1:0] fwd_y_q;
	logic [COLS-1:0]   fwd_d_q;
	logic [COLS-1:0]   rdata, row_base, wdata;
	logic              rvalid;
	logic [ROW_AW-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1    <= cmd.step;
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= cx_q;
		y_s1    <= cy_q;
		fwd_y_q <= y_s1;
		fwd_d_q <= wdata;
	end

	// the write that lands on the read edge is not in rdata yet
	always_comb begin
		if (fwd_v_q && (fwd_y_q == y_s1)) row_base = fwd_d_q;
		else if (rvalid) row_base = rdata;
		else row_base = '0;
		wdata = row_base | (COLS'(1) << x_s1);
	end

	csr_canvas_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (v_s1),
		.waddr  (y_s1),
		.wdata  (wdata),
		.re     (cmd.step | cmd.rd_row),
		.raddr  (cmd.step ? cy_q : row_q),
		.rdata  (rdata),
		.rvalid (rvalid)
	);

	// readout
	logic [COLS-1:0] row_mask;

	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			row_mask[i] = (CFG_W'(i) < weff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.row_clr) begin
			row_q <= '0;
		end else if (cmd.ld_out) begin
			row_q <= row_q + 1'b1;
		end
	end

	// output register
	logic              out_valid_q, out_err_q, out_last_q;
	logic [ROW_AW-1:0] out_row_q;
	logic [COLS-1:0]   out_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out || cmd.err_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_row_q  <= row_q;
			out_bits_q <= rvalid ? (rdata & row_mask) : '0;
			out_err_q  <= 1'b0;
			out_last_q <= sts.row_last;
		end else if (cmd.err_out) begin
			out_row_q  <= '0;
			out_bits_q <= '0;
			out_err_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, out_bits_q, out_row_q};
	assign out_err   = out_err_q;
	assign out_last  = out_last_q;

	// status
	assign sts.zero_lines = (n_lines == 3'd0);
	assign sts.ends_ok    = a_ok && b_ok;
	assign sts.at_end     = (cx_q == xb_q) && (cy_q == yb_q);
	assign sts.last_line  = ({1'b0, cmd.line_sel} == (n_lines - 3'd1));
	assign sts.row_last   = ({1'b0, row_q} == (heff - 7'd1));
	assign sts.out_free   = !out_valid_q || out_ready;

	// checks
	logic pix_inside, last_row_ok;

	assign pix_inside  = ({1'b0, cx_q} < weff) && ({1'b0, cy_q} < heff);
	assign last_row_ok = out_last_q && !out_err_q && ({1'b0, out_row_q} == (heff - 7'd1));

	`CSR_ASSERT(a_pixel_inside, clk, arst_n, !cmd.step || pix_inside)
	`CSR_ASSERT(a_readout_after_writes, clk, arst_n, !cmd.rd_row || !v_s1)
	`CSR_ASSERT(a_error_is_last, clk, arst_n, !out_valid_q || !out_err_q || out_last_q)
	`CSR_ASSERT_NEXT(a_last_row, clk, arst_n, cmd.ld_out && sts.row_last, last_row_ok)

endmodule

`default_nettype wire
